// File: design/sdpq_pkg.sv
// Shared types, constants and the date key function for the sorted date priority queue.
package sdpq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int TAG_W   = 16;
   localparam int KEY_W   = 23;
   localparam int ECNT_W  = 7;

   localparam int DAYS_PER_MONTH = 30;
   localparam int DAYS_PER_YEAR  = 300;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } rec_type;

   typedef struct packed {
      key_type key;
      rec_type rec;
   } entry_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic      ins;
      logic      pop;
      cnt_type   count;
      entry_type item;
   } cmd_type;

   function automatic key_type date_key(logic [DAY_W-1:0]   day,
                                        logic [MONTH_W-1:0] month,
                                        logic [YEAR_W-1:0]  year);
      key_type k;
      k = KEY_W'(month) * KEY_W'(DAYS_PER_MONTH)
        + KEY_W'(day)
        + KEY_W'(year) * KEY_W'(DAYS_PER_YEAR);
      return k;
   endfunction

endpackage

// File: design/sdpq_if.sv
// Valid/ready channel interfaces for queue requests and responses.
interface sdpq_req_if;
   import sdpq_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [DAY_W-1:0]     day;
   logic [MONTH_W-1:0]   month;
   logic [YEAR_W-1:0]    year;
   logic [TAG_W-1:0]     tag;

   modport source (output valid, kind, day, month, year, tag, input ready);
   modport sink   (input valid, kind, day, month, year, tag, output ready);
endinterface

interface sdpq_rsp_if;
   import sdpq_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 popped_valid;
   logic [TAG_W-1:0]     popped_tag;
   logic [DAY_W-1:0]     popped_day;
   logic [MONTH_W-1:0]   popped_month;
   logic [YEAR_W-1:0]    popped_year;
   logic [ECNT_W-1:0]    entry_count;
   logic [1:0]           status;

   modport source (output valid, popped_valid, popped_tag, popped_day, popped_month,
                   popped_year, entry_count, status, input ready);
   modport sink   (input valid, popped_valid, popped_tag, popped_day, popped_month,
                   popped_year, entry_count, status, output ready);
endinterface

// File: design/sdpq_cell.sv
// One slot of the sorted row: holds an entry and shifts with its neighbors.
module sdpq_cell (
   input  logic                clock,
   input  sdpq_pkg::idx_type   index,
   input  sdpq_pkg::cmd_type   cmd,
   input  logic                prev_le,
   input  sdpq_pkg::entry_type left_entry,
   input  sdpq_pkg::entry_type right_entry,
   output logic                le,
   output sdpq_pkg::entry_type entry
);
   import sdpq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      held;

   assign held  = CNT_W'(index) < cmd.count;
   // Held entries at or below the new key stay put; ties keep arrival order.
   assign le    = held && (entry_ff.key <= cmd.item.key);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (!le) begin
            entry_in = prev_le ? cmd.item : left_entry;
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: design/sorted_date_priority_queue_unit.sv
// Top level of the sorted date priority queue: cell row, occupancy and response register.
//
//   channel   direction  payload                                         accepted when
//   req_if    in         kind, day, month, year, tag                     valid && ready
//   rsp_if    out        popped_*, entry_count, status                   valid && ready
//
// One item per cycle while the response is not stalled: every cell compares its key with
// the new key in parallel and shifts in one step, so an insert or pop completes in the cycle
// it is accepted. The response appears in the cycle after acceptance, from an output register.
// Synchronous reset empties the queue; cell contents are left as they are.
// A stalled response holds; a new item is taken in the cycle the response leaves.
module sorted_date_priority_queue_unit (
   input  logic       clock,
   input  logic       reset,
   sdpq_req_if.sink   req_if,
   sdpq_rsp_if.source rsp_if
);
   import sdpq_pkg::*;

   cnt_type    count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       popped_valid_ff, popped_valid_in;
   rec_type    popped_ff, popped_in;
   logic [ECNT_W-1:0] ecount_ff, ecount_in;
   status_type status_ff, status_in;

   logic      accept, full, empty, do_ins, do_pop;
   cmd_type   cmd;
   entry_type new_entry;
   entry_type cell_q [QUEUE_DEPTH];
   logic      le     [QUEUE_DEPTH];

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept = req_if.valid && req_if.ready;
   assign full   = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty  = count_ff == '0;
   assign do_ins = accept && (req_if.kind == KIND_INSERT) && !full;
   assign do_pop = accept && (req_if.kind == KIND_POP) && !empty;

   assign new_entry.key       = date_key(req_if.day, req_if.month, req_if.year);
   assign new_entry.rec.tag   = req_if.tag;
   assign new_entry.rec.day   = req_if.day;
   assign new_entry.rec.month = req_if.month;
   assign new_entry.rec.year  = req_if.year;

   assign cmd.ins   = do_ins;
   assign cmd.pop   = do_pop;
   assign cmd.count = count_ff;
   assign cmd.item  = new_entry;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic      prev_le;
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_head
         assign prev_le    = 1'b1;
         assign left_entry = new_entry;
      end else begin : g_body
         assign prev_le    = le[i-1];
         assign left_entry = cell_q[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = cell_q[i];
      end else begin : g_inner
         assign right_entry = cell_q[i+1];
      end

      sdpq_cell u_cell (
         .clock       (clock),
         .index       (IDX_W'(i)),
         .cmd         (cmd),
         .prev_le     (prev_le),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .le          (le[i]),
         .entry       (cell_q[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      popped_valid_in = do_pop;
      popped_in       = do_pop ? cell_q[0].rec : '0;
      ecount_in       = ECNT_W'(count_in);
      status_in       = STATUS_OK;
      if (req_if.kind == KIND_INSERT) begin
         if (full) begin
            status_in = STATUS_FULL;
         end
      end else if (empty) begin
         status_in = STATUS_EMPTY;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload until the next item is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         popped_valid_ff <= popped_valid_in;
         popped_ff       <= popped_in;
         ecount_ff       <= ecount_in;
         status_ff       <= status_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.popped_valid = popped_valid_ff;
   assign rsp_if.popped_tag   = popped_ff.tag;
   assign rsp_if.popped_day   = popped_ff.day;
   assign rsp_if.popped_month = popped_ff.month;
   assign rsp_if.popped_year  = popped_ff.year;
   assign rsp_if.entry_count  = ecount_ff;
   assign rsp_if.status       = status_ff;

endmodule
